### rtl/glos_pkg.sv
// Shared constants and types for the grid line-of-sight march block.
package glos_pkg;

  localparam int GRID_DIM   = 64;
  localparam int CELL_W     = $clog2(GRID_DIM);
  localparam int ADDR_W     = 2 * CELL_W;
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM;

  localparam int COORD_W    = 16;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int PROD_W     = 2 * DELTA_W;
  localparam int SQ_W       = 34;
  localparam int ROOT_W     = 17;
  localparam int DIV_W      = 31;
  localparam int DVS_W      = 17;
  localparam int DIR_FRAC   = 14;
  localparam int COORD_FRAC = 8;
  localparam int SUM_FRAC   = 16;
  localparam int ACC_W      = 41;
  localparam int POS_W      = 32;
  localparam int STEP_W     = 13;
  localparam int HIT_W      = 12;
  localparam int CFG_W      = 7;

  // Step count by reciprocal multiply: ceil(2^38 / 6554) gives the exact
  // floor quotient for every length scaled to 16 fraction bits.
  localparam int SCALED_W    = ROOT_W + SUM_FRAC - COORD_FRAC;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 38;

  localparam logic [DVS_W-1:0]   STEP_Q16   = DVS_W'(6554);
  localparam logic [RECIP_W-1:0] STEP_RECIP = RECIP_W'(41940481);
  localparam logic [STEP_W-1:0]  MAX_STEPS  = STEP_W'(4096);
  localparam logic [HIT_W-1:0]   HIT_MAX    = HIT_W'(4095);

  localparam logic [0:0] KIND_WRITE = 1'b0;
  localparam logic [0:0] KIND_QUERY = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

### rtl/glos_ram.sv
// Generic single-port RAM with registered read.
module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/glos_div.sv
// Restoring divider, one quotient bit per cycle.
module glos_div
  import glos_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output unit_status_t     status
);

  logic [DVS_W-1:0]         rem;
  logic [DIV_W-1:0]         quo;
  logic [DVS_W-1:0]         dvs;
  logic [$clog2(DIV_W)-1:0] cnt;
  logic [DVS_W:0]           shifted;
  logic [DVS_W+1:0]         diff;

  assign shifted  = {rem, quo[DIV_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        rem         <= '0;
        quo         <= dividend;
        dvs         <= divisor;
        cnt         <= ($clog2(DIV_W))'(DIV_W - 1);
        status.busy <= 1'b1;
      end else if (status.busy) begin
        if (!diff[DVS_W+1]) begin
          rem <= diff[DVS_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DVS_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/glos_sqrt.sv
// Integer square root, two radicand bits per cycle.
module glos_sqrt
  import glos_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root,
  output unit_status_t      status
);

  logic [SQ_W-1:0] num;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        num         <= radicand;
        res         <= '0;
        bitv        <= SQ_W'(1) << (SQ_W - 2);
        status.busy <= 1'b1;
      end else if (status.busy) begin
        if (num >= trial) begin
          num <= num - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/grid_line_of_sight_march_top.sv
// Top level: occupancy grid memory and the line-of-sight march sequencer.
//
// Input channel (in_valid/in_stall): kind 0 writes one grid cell in the
// request cycle and produces no result; kind 1 runs a query. A query takes
// two squares on one shared 17x17 multiplier, a serial square root, two
// serial divisions (x and z direction), a reciprocal multiply for the step
// count and two more multiplies as setup, then per sample an address
// compute state and a test state on the registered read of the one-port
// grid RAM. One request is in work at a time.
// Output channel (out_valid/out_stall): hit and hit_steps sit in an output
// register until taken, so the next request is accepted while a result
// waits; a finished query holds in its last state while out_valid and out_stall are both high.
// Config port (cfg_valid/cfg_ready): ready is always high; index 0 is the
// grid width, index 1 the grid height. Write only while idle.
// Reset (rst, synchronous) returns to idle, clears out_valid and sets width
// and height to 64. Grid cells are undefined until written.
module grid_line_of_sight_march_top
  import glos_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic [CELL_W-1:0]         cell_x,
  input  logic [CELL_W-1:0]         cell_z,
  input  logic                      cell_blocked,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_z,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic [HIT_W-1:0]          hit_steps,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQZ   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_DIVX  = 4'd5;
  localparam logic [3:0] S_DIVZ  = 4'd6;
  localparam logic [3:0] S_STEPS = 4'd7;
  localparam logic [3:0] S_MULX  = 4'd8;
  localparam logic [3:0] S_MULZ  = 4'd9;
  localparam logic [3:0] S_PREP  = 4'd10;
  localparam logic [3:0] S_ADDR  = 4'd11;
  localparam logic [3:0] S_TEST  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state;

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [CFG_W-1:0] width_used;
  logic [CFG_W-1:0] height_used;

  logic signed [COORD_W-1:0] sx;
  logic signed [COORD_W-1:0] sz;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dz;
  logic [DELTA_W-1:0]        magx;
  logic [DELTA_W-1:0]        magz;

  logic signed [DELTA_W-1:0] mul_a;
  logic signed [DELTA_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [SQ_W-1:0]           sq_acc;
  logic [SQ_W-1:0]           len2;
  logic [ROOT_W-1:0]         len;

  logic [SCALED_W-1:0]         len_scaled;
  logic [SCALED_W+RECIP_W-1:0] steps_prod;
  logic [STEP_W-1:0]           steps_quo;

  logic signed [DELTA_W-1:0] dirx;
  logic signed [DELTA_W-1:0] dirz;
  logic signed [DELTA_W-1:0] dir_q;
  logic signed [PROD_W-1:0]  stepx;
  logic signed [PROD_W-1:0]  stepz_keep;
  logic [STEP_W-1:0]         steps;
  logic [STEP_W-1:0]         idx;
  logic signed [ACC_W-1:0]   accx;
  logic signed [ACC_W-1:0]   accz;
  logic signed [POS_W-1:0]   posx;
  logic signed [POS_W-1:0]   posz;
  logic                      outside;
  logic                      res_hit;
  logic [HIT_W-1:0]          res_steps;

  logic               sqrt_go;
  logic [ROOT_W-1:0]  sqrt_root;
  unit_status_t       sqrt_st;
  logic               div_go;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic [DIV_W-1:0]   div_q;
  unit_status_t       div_st;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_rdata;

  logic in_accept;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign width_used  = (grid_width  > CFG_W'(GRID_DIM)) ? CFG_W'(GRID_DIM) : grid_width;
  assign height_used = (grid_height > CFG_W'(GRID_DIM)) ? CFG_W'(GRID_DIM) : grid_height;

  assign magx = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
  assign magz = dz[DELTA_W-1] ? DELTA_W'(-dz) : DELTA_W'(dz);

  // Shared multiplier, operands picked by state, product registered.
  always_comb begin
    unique case (state)
      S_SQZ:   begin mul_a = dz;   mul_b = dz; end
      S_MULX:  begin mul_a = dirx; mul_b = $signed(STEP_Q16); end
      S_MULZ:  begin mul_a = dirz; mul_b = $signed(STEP_Q16); end
      default: begin mul_a = dx;   mul_b = dx; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    unique case (state)
      S_DIVZ: begin
        div_dividend = {magz, {DIR_FRAC{1'b0}}};
        div_divisor  = len;
      end
      default: begin
        div_dividend = {magx, {DIR_FRAC{1'b0}}};
        div_divisor  = len;
      end
    endcase
  end

  // Step count: floor(len * 2^8 / 6554) by reciprocal multiply.
  assign len_scaled = {len, {(SUM_FRAC - COORD_FRAC){1'b0}}};
  assign steps_prod = len_scaled * STEP_RECIP;
  assign steps_quo  = steps_prod[SCALED_W+RECIP_W-1:RECIP_SHIFT];

  // Signed direction from the unsigned quotient, truncated toward zero.
  always_comb begin
    if ((state == S_DIVZ) ? dz[DELTA_W-1] : dx[DELTA_W-1]) begin
      dir_q = DELTA_W'(-$signed({1'b0, div_q[DELTA_W-2:0]}));
    end else begin
      dir_q = $signed({1'b0, div_q[DELTA_W-2:0]});
    end
  end

  // Sample position with 16 fraction bits; arithmetic shifts floor.
  assign posx = $signed({{(POS_W-COORD_W-COORD_FRAC){sx[COORD_W-1]}}, sx,
                         {COORD_FRAC{1'b0}}})
              + POS_W'(accx >>> DIR_FRAC);
  assign posz = $signed({{(POS_W-COORD_W-COORD_FRAC){sz[COORD_W-1]}}, sz,
                         {COORD_FRAC{1'b0}}})
              + POS_W'(accz >>> DIR_FRAC);

  assign outside = posx[POS_W-1] || posz[POS_W-1]
                || (posx[POS_W-1:SUM_FRAC] >= (POS_W-SUM_FRAC)'(width_used))
                || (posz[POS_W-1:SUM_FRAC] >= (POS_W-SUM_FRAC)'(height_used));

  assign ram_we = in_accept && (kind == KIND_WRITE);
  always_comb begin
    if (state == S_IDLE) begin
      ram_addr = {cell_z, cell_x};
    end else begin
      ram_addr = {posz[SUM_FRAC+CELL_W-1:SUM_FRAC], posx[SUM_FRAC+CELL_W-1:SUM_FRAC]};
    end
  end

  glos_ram #(
    .WIDTH (1),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cell_blocked),
    .rdata (ram_rdata)
  );

  glos_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_go),
    .radicand (len2),
    .root     (sqrt_root),
    .status   (sqrt_st)
  );

  glos_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WIDTH) begin
        grid_width <= cfg_data;
      end else if (cfg_index == REG_HEIGHT) begin
        grid_height <= cfg_data;
      end
    end
    if (rst) begin
      grid_width  <= CFG_W'(GRID_DIM);
      grid_height <= CFG_W'(GRID_DIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sqrt_go   <= 1'b0;
      div_go    <= 1'b0;
    end else begin
      sqrt_go <= 1'b0;
      div_go  <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept && (kind == KIND_QUERY)) begin
            sx <= start_x;
            sz <= start_z;
            dx <= DELTA_W'(end_x) - DELTA_W'(start_x);
            dz <= DELTA_W'(end_z) - DELTA_W'(start_z);
            if ((end_x == start_x) && (end_z == start_z)) begin
              res_hit   <= 1'b0;
              res_steps <= '0;
              state     <= S_DONE;
            end else begin
              state <= S_SQX;
            end
          end
        end
        S_SQX: state <= S_SQZ;
        S_SQZ: begin
          sq_acc <= SQ_W'(prod);
          state  <= S_SUM;
        end
        S_SUM: begin
          len2    <= sq_acc + SQ_W'(prod);
          sqrt_go <= 1'b1;
          state   <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_st.done) begin
            len    <= sqrt_root;
            div_go <= 1'b1;
            state  <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_st.done) begin
            dirx   <= dir_q;
            div_go <= 1'b1;
            state  <= S_DIVZ;
          end
        end
        S_DIVZ: begin
          if (div_st.done) begin
            dirz  <= dir_q;
            state <= S_STEPS;
          end
        end
        S_STEPS: begin
          steps <= (steps_quo > MAX_STEPS) ? MAX_STEPS : steps_quo;
          state <= S_MULX;
        end
        S_MULX: state <= S_MULZ;
        S_MULZ: begin
          stepx <= prod;
          state <= S_PREP;
        end
        S_PREP: begin
          if (steps == '0) begin
            res_hit   <= 1'b0;
            res_steps <= '0;
            state     <= S_DONE;
          end else begin
            idx   <= STEP_W'(1);
            accx  <= ACC_W'(stepx);
            accz  <= ACC_W'(prod);
            stepx <= stepx;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (outside) begin
            res_hit   <= 1'b0;
            res_steps <= '0;
            state     <= S_DONE;
          end else begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (ram_rdata) begin
            res_hit   <= 1'b1;
            res_steps <= (idx > STEP_W'(HIT_MAX)) ? HIT_MAX : idx[HIT_W-1:0];
            state     <= S_DONE;
          end else if (idx == steps) begin
            res_hit   <= 1'b0;
            res_steps <= '0;
            state     <= S_DONE;
          end else begin
            // advance one 0.1 step along the ray
            idx   <= idx + 1'b1;
            accx  <= accx + ACC_W'(stepx);
            accz  <= accz + ACC_W'(stepz_keep);
            state <= S_ADDR;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            hit       <= res_hit;
            hit_steps <= res_steps;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      stepz_keep <= prod;
    end
  end

  sqrt_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    sqrt_st.done |-> (state == S_SQRT))
    else $error("square root finished outside its wait state");

  march_index_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> ((idx != '0) && (idx <= steps)))
    else $error("march index out of range");

  hit_has_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit ? (hit_steps != '0) : (hit_steps == '0)))
    else $error("hit_steps inconsistent with hit");

  div_only_in_setup: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIVX || state == S_DIVZ))
    else $error("divider finished outside its wait state");

endmodule

### tb/sv/grid_line_of_sight_march_top_tb.sv
// Self-checking testbench for the grid line-of-sight march block.
module grid_line_of_sight_march_top_tb
  import glos_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // only the CORNER x CORNER cells at the origin are ever loaded
  localparam int CORNER = 8;

  typedef struct {
    logic                      kind;
    logic [CELL_W-1:0]         cx;
    logic [CELL_W-1:0]         cz;
    logic                      blk;
    logic signed [COORD_W-1:0] sx, sz, ex, ez;
  } los_req_t;

  typedef struct {
    logic             hit;
    logic [HIT_W-1:0] steps;
  } sight_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic kind = KIND_WRITE;
  logic [CELL_W-1:0] cell_x = '0, cell_z = '0;
  logic cell_blocked = 1'b0;
  logic signed [COORD_W-1:0] start_x = '0, start_z = '0, end_x = '0, end_z = '0;
  logic out_valid, out_stall = 1'b0, hit;
  logic [HIT_W-1:0] hit_steps;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  grid_line_of_sight_march_top uut (.*);

  los_req_t pending_reqs[$];
  sight_t   sight_results_q[$];
  logic     wall_map[GRID_CELLS];
  logic [CFG_W-1:0] width_reg = 7'd64, height_reg = 7'd64;
  int  pushed_cnt = 0, accepted_cnt = 0, errors = 0;
  bit  steady = 1'b0;
  bit  in_took = 1'b0, out_took = 1'b0;
  int  in_gap = 0, stall_cnt = 0;

  initial forever #1 clk = ~clk;

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic sight_t predict_sight(los_req_t q);
    sight_t res;
    longint dx, dz, sx16, sz16, len, nsteps, dirx, dirz, t, px, pz, mx, mz, w, h;
    res.hit = 1'b0;
    res.steps = '0;
    dx = longint'(q.ex) - longint'(q.sx);
    dz = longint'(q.ez) - longint'(q.sz);
    if (dx == 0 && dz == 0) return res;
    sx16 = longint'(q.sx) * 256;
    sz16 = longint'(q.sz) * 256;
    w = (width_reg > GRID_DIM) ? GRID_DIM : width_reg;
    h = (height_reg > GRID_DIM) ? GRID_DIM : height_reg;
    len = root_floor(dx * dx + dz * dz);
    dirx = ((dx < 0 ? -dx : dx) << DIR_FRAC) / len;
    if (dx < 0) dirx = -dirx;
    dirz = ((dz < 0 ? -dz : dz) << DIR_FRAC) / len;
    if (dz < 0) dirz = -dirz;
    nsteps = (len << (SUM_FRAC - COORD_FRAC)) / 6554;
    if (nsteps > 4096) nsteps = 4096;
    for (longint i = 1; i <= nsteps; i++) begin
      t = i * 6554;
      px = sx16 + ((dirx * t) >>> DIR_FRAC);
      pz = sz16 + ((dirz * t) >>> DIR_FRAC);
      mx = px >>> SUM_FRAC;
      mz = pz >>> SUM_FRAC;
      if (mx < 0 || mz < 0 || mx >= w || mz >= h) return res;
      if (wall_map[mz * GRID_DIM + mx]) begin
        res.hit = 1'b1;
        res.steps = (i > 4095) ? HIT_MAX : HIT_W'(i);
        return res;
      end
    end
    return res;
  endfunction

  // accept side: update the grid copy or predict the query
  always @(posedge clk) begin
    sight_t p;
    in_took <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      accepted_cnt <= accepted_cnt + 1;
      if (kind == KIND_WRITE) begin
        wall_map[{cell_z, cell_x}] = cell_blocked;
      end else begin
        p = predict_sight('{kind, cell_x, cell_z, cell_blocked,
                            start_x, start_z, end_x, end_z});
        sight_results_q = {sight_results_q, p};
      end
    end
  end

  always @(negedge clk) begin
    los_req_t r;
    if (!rst && !(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        kind <= r.kind; cell_x <= r.cx; cell_z <= r.cz; cell_blocked <= r.blk;
        start_x <= r.sx; start_z <= r.sz; end_x <= r.ex; end_z <= r.ez;
        in_valid <= 1'b1;
        in_gap <= steady ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sight_t e;
    out_took <= out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      if (sight_results_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0d steps=%0d", hit, hit_steps);
      end else begin
        e = sight_results_q.pop_front();
        if (e.hit !== hit || e.steps !== hit_steps) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected hit=%0d steps=%0d, got hit=%0d steps=%0d",
                     e.hit, e.steps, hit, hit_steps);
        end
      end
    end
  end

  // stall the result side for a random count after each taken result
  always @(negedge clk) begin
    if (out_took) stall_cnt = steady ? 0 : $urandom_range(0, 6);
    else if (stall_cnt > 0) stall_cnt--;
    out_stall <= (stall_cnt > 0);
  end

  task automatic put_cell(int x, int z, bit b);
    los_req_t r;
    r = '{KIND_WRITE, CELL_W'(x), CELL_W'(z), b, '0, '0, '0, '0};
    pending_reqs = {pending_reqs, r};
    pushed_cnt++;
  endtask

  task automatic put_query(int sx, int sz, int ex, int ez);
    los_req_t r;
    r = '{KIND_QUERY, CELL_W'($urandom), CELL_W'($urandom), 1'($urandom),
          COORD_W'(sx), COORD_W'(sz), COORD_W'(ex), COORD_W'(ez)};
    pending_reqs = {pending_reqs, r};
    pushed_cnt++;
  endtask

  // a coordinate well inside the loaded corner
  function automatic int inner_coord();
    return int'($urandom_range(32, CORNER * 256 - 32));
  endfunction

  task automatic drain();
    while (accepted_cnt != pushed_cnt || sight_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // confined: the grid in use is larger than the loaded corner, so keep
  // both ends of every query inside the corner
  task automatic random_mix(int n, bit confined);
    int sx, sz;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9)) inside
        [0:2]: put_cell($urandom_range(0, CORNER - 1), $urandom_range(0, CORNER - 1),
                        $urandom_range(0, 3) == 0);
        3: begin
          if (confined) put_query(inner_coord(), inner_coord(), inner_coord(), inner_coord());
          else put_query($urandom, $urandom, $urandom, $urandom);
        end
        default: begin
          if (confined) begin
            put_query(inner_coord(), inner_coord(), inner_coord(), inner_coord());
          end else begin
            sx = int'($urandom_range(0, CORNER * 256 + 511)) - 256;
            sz = int'($urandom_range(0, CORNER * 256 + 511)) - 256;
            put_query(sx, sz, sx + int'($urandom_range(0, 4000)) - 2000,
                      sz + int'($urandom_range(0, 4000)) - 2000);
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // shrink the grid to the corner and load every cell of it once
    set_reg(REG_WIDTH, 7'(CORNER));
    set_reg(REG_HEIGHT, 7'(CORNER));
    for (int z = 0; z < CORNER; z++)
      for (int x = 0; x < CORNER; x++) put_cell(x, z, $urandom_range(0, 4) == 0);

    // directed part
    put_cell(2, 2, 1'b1);
    put_query(2 * 256 + 128, 2 * 256 + 128, 6 * 256, 2 * 256);        // blocked start cell
    put_cell(5, 2, 1'b1);
    put_query(2 * 256 + 128, 2 * 256 + 128, 7 * 256, 2 * 256 + 128);
    put_query(1000, 1000, 1000, 1000);                              // zero length
    put_query(4 * 256, 4 * 256, -32768, -32768);                    // leave low side
    put_query(4 * 256, 4 * 256, 32767, 32767);                      // leave high side
    put_query(-32768, 32767, 32767, -32768);
    put_query(32767, 32767, -32768, -32768);
    put_query(0, 0, 7 * 256 + 255, 7 * 256 + 255);
    put_query(7 * 256 + 255, 0, 0, 7 * 256 + 255);
    put_cell(7, 7, 1'b1);
    put_query(0, 0, 16383, 16383);
    put_cell(7, 7, 1'b0);
    drain();

    steady = 1'b1;
    random_mix(20, 1'b0);
    drain();
    steady = 1'b0;

    set_reg(REG_WIDTH, 7'd1);
    set_reg(REG_HEIGHT, 7'd1);
    put_query(128, 128, 255, 200);
    put_query(10, 10, 4000, 10);
    random_mix(6, 1'b0);
    drain();

    set_reg(REG_WIDTH, 7'd0);
    put_query(128, 128, 3000, 3000);
    drain();

    set_reg(REG_WIDTH, 7'd127);
    set_reg(REG_HEIGHT, 7'd100);
    random_mix(12, 1'b1);
    drain();

    set_reg(REG_WIDTH, 7'($urandom_range(2, CORNER)));
    set_reg(REG_HEIGHT, 7'($urandom_range(2, CORNER)));
    random_mix(12, 1'b0);
    drain();

    set_reg(REG_WIDTH, 7'd64);
    set_reg(REG_HEIGHT, 7'd64);
    random_mix(12, 1'b1);
    drain();
    repeat (30) @(posedge clk);

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/glos_pkg.sv
rtl/glos_ram.sv
rtl/glos_div.sv
rtl/glos_sqrt.sv
rtl/grid_line_of_sight_march_top.sv
tb/sv/grid_line_of_sight_march_top_tb.sv
